### src/rbdq_pkg.sv
// shared widths, operation codes and status codes for the ring buffer deque
// no dependencies
`default_nettype none

package rbdq_pkg;

  localparam int unsigned CAP_W     = 9;   // capacity and count width
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IO_DATA_W = 32;  // element width on the ports

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t FUNC_PUSH_FRONT = 2'd0;
  localparam func_t FUNC_PUSH_REAR  = 2'd1;
  localparam func_t FUNC_POP_FRONT  = 2'd2;
  localparam func_t FUNC_POP_REAR   = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

### src/rbdq_req_if.sv
// valid/ready channel carrying one deque operation
// depends on rbdq_pkg
`default_nettype none

interface rbdq_req_if;
  import rbdq_pkg::*;

  logic                 valid;
  logic                 ready;
  func_t                func;
  logic [IO_DATA_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

`default_nettype wire

### src/rbdq_rsp_if.sv
// valid/ready channel carrying one deque result
// depends on rbdq_pkg
`default_nettype none

interface rbdq_rsp_if;
  import rbdq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IO_DATA_W-1:0] pop_value;
  status_t              status;
  logic [CAP_W-1:0]     count;
  logic                 is_empty;
  logic                 is_full;
  logic [IO_DATA_W-1:0] front_value;
  logic [IO_DATA_W-1:0] rear_value;

  modport source (output valid, output pop_value, output status, output count,
                  output is_empty, output is_full, output front_value,
                  output rear_value, input ready);
  modport sink   (input valid, input pop_value, input status, input count,
                  input is_empty, input is_full, input front_value,
                  input rear_value, output ready);
endinterface

`default_nettype wire

### src/rbdq_ram.sv
// element store: one write port, one registered read port
// write-first: a read of the address being written returns the new data
`default_nettype none

module rbdq_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/ring_buffer_deque_top.sv
// ring buffer deque: top level with operation decode, state and result register
// depends on rbdq_pkg, rbdq_req_if, rbdq_rsp_if and rbdq_ram
`default_nettype none

// Double-ended queue kept in a ring of slots. Each transfer on req asks for
// push front, push rear, pop front or pop rear; each produces exactly one
// transfer on rsp with the popped value (zero unless a pop succeeded), a
// status (ok, full, empty), the count, empty/full flags and the front and rear
// elements after the operation (zero when the deque is empty). A rejected
// operation leaves the state alone. Throughput is one operation per clock
// while rsp.ready stays high: an accepted operation is held in the input
// register and resolved from there into the result register, which drives rsp.
// With rsp held off, the input and result registers hold two operations
// and req.ready stays low until rsp moves. The ring store has a single
// read port; front and rear elements are cached in registers and the port
// prefetches, at accept time, the element that becomes the new front or
// rear if the operation is a pop. Writing cfg_we loads the capacity (zero
// acts as 1, values above DEPTH act as DEPTH) and empties the deque; write
// it only while no operation is in flight. Slot contents are not cleared
// at reset.

module ring_buffer_deque_top #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rbdq_pkg::CAP_W-1:0]    cfg_wdata,
  rbdq_req_if.sink                           req,
  rbdq_rsp_if.source                         rsp
);
  import rbdq_pkg::*;

  // slots beyond what the capacity register can address are never used
  localparam int unsigned DEPTH_CAP = (DEPTH > ((1 << CAP_W) - 1)) ?
                                      ((1 << CAP_W) - 1) : DEPTH;
  localparam int unsigned IDX_W     = (DEPTH_CAP > 1) ? $clog2(DEPTH_CAP) : 1;
  localparam int unsigned SUM_W     = CAP_W + 1;

  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH_CAP);

  // index arithmetic, valid for s < 2 * c
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s,
                                                 input logic [SUM_W-1:0] c);
    logic [SUM_W-1:0] r;
    r = (s >= c) ? (s - c) : s;
    return r[IDX_W-1:0];
  endfunction

  // configuration and deque state
  logic [CAP_W-1:0]      capacity;
  logic [IDX_W-1:0]      head;
  logic [CAP_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] front_val;
  logic [DATA_WIDTH-1:0] rear_val;

  // input register
  logic                  s1_valid;
  func_t                 s1_func;
  logic [DATA_WIDTH-1:0] s1_value;

  // result register
  logic                  out_valid;
  logic [IO_DATA_W-1:0]  out_pop;
  status_t               out_status;
  logic [CAP_W-1:0]      out_count;
  logic                  out_empty;
  logic                  out_full;
  logic [IO_DATA_W-1:0]  out_front;
  logic [IO_DATA_W-1:0]  out_rear;

  // handshake
  logic load_out;
  logic accept;

  // store ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // effective capacity and decode of the staged operation
  logic [CAP_W-1:0]      eff_cap;
  logic [SUM_W-1:0]      cap_ext;
  logic                  is_full_now;
  logic                  is_empty_now;
  logic [IDX_W-1:0]      head_prev;
  logic [IDX_W-1:0]      head_inc;
  logic [IDX_W-1:0]      tail_idx;

  logic [IDX_W-1:0]      head_next;
  logic [CAP_W-1:0]      cnt_next;
  logic [DATA_WIDTH-1:0] front_next;
  logic [DATA_WIDTH-1:0] rear_next;
  logic [DATA_WIDTH-1:0] popped;
  status_t               status_next;

  // prefetch address for the operation being accepted
  logic [IDX_W-1:0]      base_head;
  logic [CAP_W-1:0]      base_cnt;
  logic [IDX_W-1:0]      pf_front;
  logic [IDX_W-1:0]      pf_end;
  logic [SUM_W-1:0]      pf_rear_s;

  assign load_out  = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || load_out;
  assign accept    = req.valid && req.ready;

  // zero acts as one, anything past the store acts as the store size
  always_comb begin
    priority if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (capacity > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end else begin
      eff_cap = capacity;
    end
  end

  assign cap_ext      = SUM_W'(eff_cap);
  assign is_full_now  = (cnt >= eff_cap);
  assign is_empty_now = (cnt == '0);
  assign head_prev    = (head == '0) ? IDX_W'(eff_cap - CAP_W'(1)) : (head - IDX_W'(1));
  assign head_inc     = wrap_idx(SUM_W'(head) + SUM_W'(1), cap_ext);
  assign tail_idx     = wrap_idx(SUM_W'(head) + SUM_W'(cnt), cap_ext);

  // resolve the staged operation against the current state
  always_comb begin
    head_next   = head;
    cnt_next    = cnt;
    front_next  = front_val;
    rear_next   = rear_val;
    popped      = '0;
    status_next = ST_OK;
    ram_we      = 1'b0;
    ram_waddr   = head_prev;
    unique case (s1_func)
      FUNC_PUSH_FRONT: begin
        if (is_full_now) begin
          status_next = ST_FULL;
        end else begin
          ram_we     = load_out;
          ram_waddr  = head_prev;
          head_next  = head_prev;
          cnt_next   = cnt + CAP_W'(1);
          front_next = s1_value;
          if (is_empty_now) begin
            rear_next = s1_value;
          end
        end
      end
      FUNC_PUSH_REAR: begin
        if (is_full_now) begin
          status_next = ST_FULL;
        end else begin
          ram_we    = load_out;
          ram_waddr = tail_idx;
          cnt_next  = cnt + CAP_W'(1);
          rear_next = s1_value;
          if (is_empty_now) begin
            front_next = s1_value;
          end
        end
      end
      FUNC_POP_FRONT: begin
        if (is_empty_now) begin
          status_next = ST_EMPTY;
        end else begin
          popped     = front_val;
          head_next  = head_inc;
          cnt_next   = cnt - CAP_W'(1);
          // prefetched element behind the old front
          front_next = ram_rdata;
        end
      end
      FUNC_POP_REAR: begin
        if (is_empty_now) begin
          status_next = ST_EMPTY;
        end else begin
          popped    = rear_val;
          cnt_next  = cnt - CAP_W'(1);
          // prefetched element ahead of the old rear
          rear_next = ram_rdata;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // prefetch for the incoming operation uses the state it will see
  assign base_head = load_out ? head_next : head;
  assign base_cnt  = load_out ? cnt_next : cnt;
  assign pf_front  = wrap_idx(SUM_W'(base_head) + SUM_W'(1), cap_ext);
  assign pf_end    = wrap_idx(SUM_W'(base_head) + SUM_W'(base_cnt), cap_ext);
  // slot two before the end, i.e. one before the rear
  assign pf_rear_s = (SUM_W'(pf_end) >= SUM_W'(2)) ?
                     (SUM_W'(pf_end) - SUM_W'(2)) :
                     (SUM_W'(pf_end) + cap_ext - SUM_W'(2));
  assign ram_raddr = (req.func == FUNC_POP_REAR) ? pf_rear_s[IDX_W-1:0] : pf_front;

  rbdq_ram #(
    .DEPTH (DEPTH_CAP),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s1_value),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      head      <= '0;
      cnt       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        // a capacity write empties the deque
        capacity <= cfg_wdata;
        head     <= '0;
        cnt      <= '0;
      end else if (load_out) begin
        head <= head_next;
        cnt  <= cnt_next;
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (load_out) begin
        s1_valid <= 1'b0;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func  <= req.func;
      s1_value <= DATA_WIDTH'(req.push_value);
    end
    if (load_out) begin
      front_val  <= front_next;
      rear_val   <= rear_next;
      out_pop    <= IO_DATA_W'(popped);
      out_status <= status_next;
      out_count  <= cnt_next;
      out_empty  <= (cnt_next == '0);
      out_full   <= (cnt_next == eff_cap);
      out_front  <= (cnt_next != '0) ? IO_DATA_W'(front_next) : '0;
      out_rear   <= (cnt_next != '0) ? IO_DATA_W'(rear_next) : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pop_value   = out_pop;
  assign rsp.status      = out_status;
  assign rsp.count       = out_count;
  assign rsp.is_empty    = out_empty;
  assign rsp.is_full     = out_full;
  assign rsp.front_value = out_front;
  assign rsp.rear_value  = out_rear;

endmodule

`default_nettype wire
